FILE: design/mlpq_pkg.sv
package mlpq_pkg;

  localparam int DEF_NUM_LEVELS    = 8;
  localparam int DEF_LEVEL_DEPTH   = 16;
  localparam int DEF_PAYLOAD_WIDTH = 32;

  localparam int PRIO_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_BADPRI = 3'd3,
    ST_NULL   = 3'd4
  } status_t;

  // Outcome of one request as decided by the level controller.
  typedef struct packed {
    status_t status;
    logic    pop_valid;
    logic    all_empty;
  } result_t;

endpackage

FILE: design/mlpq_store.sv
module mlpq_store import mlpq_pkg::*; #(
  parameter int DEPTH = DEF_NUM_LEVELS * DEF_LEVEL_DEPTH,
  parameter int DW    = DEF_PAYLOAD_WIDTH,
  parameter int AW    = $clog2(DEF_NUM_LEVELS * DEF_LEVEL_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic          rd_en,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Read data stays put until the next pop reads the array.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: design/mlpq_ctrl.sv
module mlpq_ctrl import mlpq_pkg::*; #(
  parameter int NUM_LEVELS  = DEF_NUM_LEVELS,
  parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH,
  parameter int AW          = $clog2(DEF_NUM_LEVELS * DEF_LEVEL_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic              command,
  input  logic [PRIO_W-1:0] priority_req,
  input  logic              element_present,
  output result_t           res,
  output logic              wr_en,
  output logic              rd_en,
  output logic [AW-1:0]     addr
);

  localparam int LW = $clog2(NUM_LEVELS);
  localparam int PW = $clog2(LEVEL_DEPTH);
  localparam int CW = $clog2(LEVEL_DEPTH + 1);

  logic [PW-1:0] head  [NUM_LEVELS];
  logic [PW-1:0] tail  [NUM_LEVELS];
  logic [CW-1:0] count [NUM_LEVELS];
  logic [CW-1:0] count_next [NUM_LEVELS];

  logic          bad_prio;
  logic          found;
  logic [LW-1:0] push_lvl;
  logic [LW-1:0] pop_lvl;
  logic [LW-1:0] sel_lvl;
  logic [CW-1:0] sel_count;
  logic [PW-1:0] ptr;
  logic [PW-1:0] ptr_next;
  logic          do_push;
  logic          do_pop;
  logic          empty_all;

  always_comb begin
    bad_prio = (priority_req == '0) || (priority_req > PRIO_W'(NUM_LEVELS));
    push_lvl = bad_prio ? '0 : LW'(PRIO_W'(NUM_LEVELS) - priority_req);

    // Lowest index with entries wins; scan from the top so it lands last.
    found   = 1'b0;
    pop_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        found   = 1'b1;
        pop_lvl = LW'(i);
      end
    end

    sel_lvl   = (command == CMD_POP) ? pop_lvl : push_lvl;
    sel_count = count[sel_lvl];
    ptr       = (command == CMD_POP) ? head[sel_lvl] : tail[sel_lvl];
    ptr_next  = (ptr == PW'(LEVEL_DEPTH - 1)) ? '0 : ptr + 1'b1;
    addr      = AW'(int'(sel_lvl) * LEVEL_DEPTH) + AW'(ptr);

    do_push    = 1'b0;
    do_pop     = 1'b0;
    res.status = ST_OK;
    if (command == CMD_POP) begin
      if (found) begin
        do_pop = 1'b1;
      end else begin
        res.status = ST_EMPTY;
      end
    end else begin
      priority if (!element_present) begin
        res.status = ST_NULL;
      end else if (bad_prio) begin
        res.status = ST_BADPRI;
      end else if (sel_count == CW'(LEVEL_DEPTH)) begin
        res.status = ST_FULL;
      end else begin
        do_push = 1'b1;
      end
    end

    empty_all = 1'b1;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      count_next[i] = count[i];
      if (LW'(i) == sel_lvl) begin
        if (do_push) begin
          count_next[i] = count[i] + 1'b1;
        end else if (do_pop) begin
          count_next[i] = count[i] - 1'b1;
        end
      end
      if (count_next[i] != '0) begin
        empty_all = 1'b0;
      end
    end

    res.pop_valid = do_pop;
    res.all_empty = empty_all;
    wr_en         = take && do_push;
    rd_en         = take && do_pop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else if (take) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        count[i] <= count_next[i];
      end
      if (do_push) begin
        tail[sel_lvl] <= ptr_next;
      end
      if (do_pop) begin
        head[sel_lvl] <= ptr_next;
      end
    end
  end

  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_chk
    a_count_bound: assert property (@(posedge clk) disable iff (rst)
      count[g] <= CW'(LEVEL_DEPTH))
      else $error("level fill count above depth");
  end

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> count[sel_lvl] != '0)
    else $error("pop issued on an empty level");

endmodule

FILE: design/multi_level_priority_queue.sv
// Strict-priority queue with one FIFO of LEVEL_DEPTH entries per priority level, all held
// in one single-port entry memory. A push with priority 1..NUM_LEVELS goes to level
// NUM_LEVELS - priority; a pop takes the head of the lowest-numbered non-empty level.
// Each request gives exactly one result, in the cycle after it is accepted, and a new
// request can be accepted every cycle: head, tail and fill count of each level live in
// registers that are updated at acceptance, and the entry memory sees at most one read
// or one write per request. The input stalls only while a result is held by out_stall.
// Entries are not cleared at reset and need no clearing pass; counts start at zero.
module multi_level_priority_queue import mlpq_pkg::*; #(
  parameter int NUM_LEVELS    = DEF_NUM_LEVELS,
  parameter int LEVEL_DEPTH   = DEF_LEVEL_DEPTH,
  parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              command,
  input  logic [PRIO_W-1:0] priority_req,
  input  logic              element_present,
  input  logic [DATA_W-1:0] payload,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic              pop_valid,
  output logic [DATA_W-1:0] popped_payload,
  output logic              all_empty
);

  localparam int DEPTH = NUM_LEVELS * LEVEL_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  logic                     take;
  result_t                  res;
  result_t                  res_q;
  logic                     wr_en;
  logic                     rd_en;
  logic [AW-1:0]            addr;
  logic [PAYLOAD_WIDTH-1:0] rdata;

  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  mlpq_ctrl #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .command         (command),
    .priority_req    (priority_req),
    .element_present (element_present),
    .res             (res),
    .wr_en           (wr_en),
    .rd_en           (rd_en),
    .addr            (addr)
  );

  mlpq_store #(
    .DEPTH (DEPTH),
    .DW    (PAYLOAD_WIDTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .wr_en (wr_en),
    .rd_en (rd_en),
    .addr  (addr),
    .wdata (PAYLOAD_WIDTH'(payload)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res;
    end
  end

  assign status         = res_q.status;
  assign pop_valid      = res_q.pop_valid;
  assign all_empty      = res_q.all_empty;
  assign popped_payload = res_q.pop_valid ? DATA_W'(rdata) : '0;

  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pop_valid) |-> (res_q.status == ST_OK))
    else $error("popped element reported with a failing status");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_q.status == ST_EMPTY) |-> (all_empty && !pop_valid))
    else $error("empty pop reported with entries left");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("accepted request produced no result");

endmodule
